// ===== sv/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg: shared types and constants of the LED pattern sequencer
// Mode codes, register indexes, reset values and the structs that pass
// between the register file, the step logic and the top level.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned LED_OUT_W  = 8;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_BLINK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_BLINK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_BLINK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHASE_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_STEP    = 3'd4;

  // Register reset values, in ticks
  localparam logic [DELAY_W-1:0] FAST_BLINK_RST   = 16'd100;
  localparam logic [DELAY_W-1:0] MEDIUM_BLINK_RST = 16'd300;
  localparam logic [DELAY_W-1:0] SLOW_BLINK_RST   = 16'd600;
  localparam logic [DELAY_W-1:0] CHASE_STEP_RST   = 16'd80;
  localparam logic [DELAY_W-1:0] WAIT_STEP_RST    = 16'd60;

  // Request kinds
  localparam logic ACT_STEP     = 1'b0;
  localparam logic ACT_SET_MODE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF     = 3'd0,
    MODE_ON      = 3'd1,
    MODE_LEFT    = 3'd2,
    MODE_RIGHT   = 3'd3,
    MODE_FAST    = 3'd4,
    MODE_MEDIUM  = 3'd5,
    MODE_SLOW    = 3'd6,
    MODE_WAITING = 3'd7
  } lps_mode_e;

  typedef struct packed {
    logic [DELAY_W-1:0] fast_blink_time;
    logic [DELAY_W-1:0] medium_blink_time;
    logic [DELAY_W-1:0] slow_blink_time;
    logic [DELAY_W-1:0] chase_step_time;
    logic [DELAY_W-1:0] wait_step_time;
  } lps_cfg_t;

  typedef struct packed {
    logic [LED_OUT_W-1:0] led_pattern;
    logic                 start_timer;
    logic [DELAY_W-1:0]   delay_ticks;
    lps_mode_e            mode_now;
    logic                 turn_busy;
  } lps_result_t;

endpackage

// ===== sv/led_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// led_pattern_sequencer: eight-mode LED row sequencer
// Registers each request, steps the pattern state and holds the
// result in an output register until it is taken.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | input     | in_valid_i / in_stall_o | in_action_i, in_new_mode_i
//  out     | output    | out_valid_o/out_stall_i | led_pattern, start_timer,
//          |           |                         | delay_ticks, mode_now, turn_busy
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  A request is held in the input register while the step logic works on
//  it; its result is loaded into the output register when it is stepped.
//  One request per cycle is sustained while the output is not stalled.
//  Reset clears the pattern state and loads the register defaults; no
//  clearing pass. A stalled output holds the result and backs up the input
//  register; the input stalls only when both stages are full and the output
//  is stalled.
// ----------------------------------------------------------------------------
module led_pattern_sequencer
  import lps_pkg::*;
#(
  parameter int unsigned LED_COUNT   = 8,
  parameter int unsigned LOOP_COUNT  = 3,
  parameter int unsigned RIGHT_START = 3,
  parameter int unsigned LEFT_START  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 in_action_i,
  input  logic [MODE_W-1:0]    in_new_mode_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LED_OUT_W-1:0] out_led_pattern_o,
  output logic                 out_start_timer_o,
  output logic [DELAY_W-1:0]   out_delay_ticks_o,
  output logic [MODE_W-1:0]    out_mode_now_o,
  output logic                 out_turn_busy_o,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DELAY_W-1:0]   cfg_data_i
);

  logic              in_valid_q;
  logic              action_q;
  logic [MODE_W-1:0] new_mode_q;
  logic              out_valid_q;
  lps_result_t       result_q;
  lps_result_t       result;
  lps_cfg_t          cfg;
  logic              step_en;
  logic              in_take;

  lps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lps_step #(
    .LED_COUNT  (LED_COUNT),
    .LOOP_COUNT (LOOP_COUNT),
    .RIGHT_START(RIGHT_START),
    .LEFT_START (LEFT_START)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .action_i  (action_q),
    .new_mode_i(new_mode_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  // Process the held request when the result register is free
  assign step_en    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step_en;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step_en) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q   <= in_action_i;
      new_mode_q <= in_new_mode_i;
    end
  end

  // Result register: load on step, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      result_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_led_pattern_o = result_q.led_pattern;
  assign out_start_timer_o = result_q.start_timer;
  assign out_delay_ticks_o = result_q.delay_ticks;
  assign out_mode_now_o    = result_q.mode_now;
  assign out_turn_busy_o   = result_q.turn_busy;

endmodule

// ===== sv/lps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lps_cfg_regs: timing register file
// Holds the five delay registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lps_cfg_regs
  import lps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DELAY_W-1:0]   cfg_data_i,
  output lps_cfg_t             cfg_o
);

  lps_cfg_t cfg_q;

  // Always able to take a write
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Load the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_blink_time   <= FAST_BLINK_RST;
      cfg_q.medium_blink_time <= MEDIUM_BLINK_RST;
      cfg_q.slow_blink_time   <= SLOW_BLINK_RST;
      cfg_q.chase_step_time   <= CHASE_STEP_RST;
      cfg_q.wait_step_time    <= WAIT_STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FAST_BLINK:   cfg_q.fast_blink_time   <= cfg_data_i;
        CFG_MEDIUM_BLINK: cfg_q.medium_blink_time <= cfg_data_i;
        CFG_SLOW_BLINK:   cfg_q.slow_blink_time   <= cfg_data_i;
        CFG_CHASE_STEP:   cfg_q.chase_step_time   <= cfg_data_i;
        CFG_WAIT_STEP:    cfg_q.wait_step_time    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/lps_step.sv =====
// ----------------------------------------------------------------------------
// lps_step: pattern state and single-step logic
// Holds the LED row, blink phase, mode and chase/waiting indices, and works
// out the next state and the result of one request.
// ----------------------------------------------------------------------------
module lps_step
  import lps_pkg::*;
#(
  parameter int unsigned LED_COUNT   = 8,
  parameter int unsigned LOOP_COUNT  = 3,
  parameter int unsigned RIGHT_START = 3,
  parameter int unsigned LEFT_START  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  logic              action_i,
  input  logic [MODE_W-1:0] new_mode_i,
  input  lps_cfg_t          cfg_i,
  output lps_result_t       result_o
);

  localparam int unsigned CHASE_TOTAL = LOOP_COUNT * LED_COUNT;
  localparam int unsigned STEP_W      = $clog2(CHASE_TOTAL + 1);
  localparam int unsigned CIDX_W      = $clog2(LED_COUNT);
  localparam int unsigned MAX_A       = (LED_COUNT > RIGHT_START) ? LED_COUNT : RIGHT_START;
  localparam int unsigned MAX_B       = (MAX_A > LEFT_START) ? MAX_A : LEFT_START;
  localparam int unsigned OUT_W       = $clog2(MAX_B + 1);
  localparam int unsigned PAT_W       = (LED_COUNT > LED_OUT_W) ? LED_COUNT : LED_OUT_W;

  logic [LED_COUNT-1:0] pattern_q, pattern_d;
  logic                 phase_q, phase_d;
  lps_mode_e            mode_q, mode_d;
  logic [CIDX_W-1:0]    chase_idx_q, chase_idx_d;
  logic [STEP_W-1:0]    chase_steps_q, chase_steps_d;
  logic                 chase_active_q, chase_active_d;
  logic [OUT_W-1:0]     right_idx_q, right_idx_d;
  logic [OUT_W-1:0]     left_idx_q, left_idx_d;

  logic [CIDX_W-1:0]    cur_idx;
  logic [LED_COUNT-1:0] chase_bit;
  logic [LED_COUNT-1:0] wait_bits;
  logic [OUT_W:0]       left_inc;
  logic                 start_timer;
  logic [DELAY_W-1:0]   delay_ticks;
  logic [PAT_W-1:0]     pattern_ext;

  // Chase starts fresh from its end LED when no run is pending
  always_comb begin
    if (chase_steps_q == '0) begin
      cur_idx = (mode_q == MODE_LEFT) ? '0 : CIDX_W'(LED_COUNT - 1);
    end else begin
      cur_idx = chase_idx_q;
    end
  end

  // Decode the LED masks; an index past the row lights nothing
  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      chase_bit[i] = (cur_idx == CIDX_W'(i));
      wait_bits[i] = (right_idx_q == OUT_W'(i)) || (left_idx_q == OUT_W'(i));
    end
  end

  assign left_inc = {1'b0, left_idx_q} + (OUT_W+1)'(1);

  // Next state and result of one request
  always_comb begin
    pattern_d      = pattern_q;
    phase_d        = phase_q;
    mode_d         = mode_q;
    chase_idx_d    = chase_idx_q;
    chase_steps_d  = chase_steps_q;
    chase_active_d = chase_active_q;
    right_idx_d    = right_idx_q;
    left_idx_d     = left_idx_q;
    start_timer    = 1'b0;
    delay_ticks    = '0;

    if (action_i == ACT_SET_MODE) begin
      mode_d = lps_mode_e'(new_mode_i);
    end else begin
      case (mode_q)
        MODE_OFF: begin
          pattern_d = '0;
        end
        MODE_ON: begin
          pattern_d = '1;
        end
        MODE_LEFT, MODE_RIGHT: begin
          pattern_d = '0;
          if (chase_steps_q < STEP_W'(CHASE_TOTAL)) begin
            chase_active_d = 1'b1;
            chase_steps_d  = chase_steps_q + STEP_W'(1);
            pattern_d      = chase_bit;
            if (mode_q == MODE_LEFT) begin
              chase_idx_d = (cur_idx == CIDX_W'(LED_COUNT - 1)) ? '0 : cur_idx + CIDX_W'(1);
            end else begin
              chase_idx_d = (cur_idx == '0) ? CIDX_W'(LED_COUNT - 1) : cur_idx - CIDX_W'(1);
            end
            start_timer = 1'b1;
            delay_ticks = cfg_i.chase_step_time;
          end else begin
            // Run complete: clear the row and fall back to all off
            chase_idx_d    = '0;
            chase_steps_d  = '0;
            chase_active_d = 1'b0;
            mode_d         = MODE_OFF;
          end
        end
        MODE_FAST, MODE_MEDIUM, MODE_SLOW: begin
          phase_d     = ~phase_q;
          pattern_d   = phase_d ? '1 : '0;
          start_timer = 1'b1;
          if (mode_q == MODE_FAST) begin
            delay_ticks = cfg_i.fast_blink_time;
          end else if (mode_q == MODE_MEDIUM) begin
            delay_ticks = cfg_i.medium_blink_time;
          end else begin
            delay_ticks = phase_d ? cfg_i.slow_blink_time : cfg_i.medium_blink_time;
          end
        end
        default: begin
          // Waiting: two LEDs run outward, each reloading at its end
          pattern_d   = wait_bits;
          right_idx_d = (right_idx_q == '0) ? OUT_W'(RIGHT_START) : right_idx_q - OUT_W'(1);
          left_idx_d  = (left_inc >= (OUT_W+1)'(LED_COUNT)) ? OUT_W'(LEFT_START)
                                                             : left_inc[OUT_W-1:0];
          start_timer = 1'b1;
          delay_ticks = cfg_i.wait_step_time;
        end
      endcase
    end
  end

  // Advance state on each processed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q      <= '0;
      phase_q        <= 1'b0;
      mode_q         <= MODE_OFF;
      chase_idx_q    <= '0;
      chase_steps_q  <= '0;
      chase_active_q <= 1'b0;
      right_idx_q    <= '0;
      left_idx_q     <= '0;
    end else if (step_en_i) begin
      pattern_q      <= pattern_d;
      phase_q        <= phase_d;
      mode_q         <= mode_d;
      chase_idx_q    <= chase_idx_d;
      chase_steps_q  <= chase_steps_d;
      chase_active_q <= chase_active_d;
      right_idx_q    <= right_idx_d;
      left_idx_q     <= left_idx_d;
    end
  end

  // Only the low eight LEDs are visible at the port
  assign pattern_ext          = PAT_W'(pattern_d);
  assign result_o.led_pattern = pattern_ext[LED_OUT_W-1:0];
  assign result_o.start_timer = start_timer;
  assign result_o.delay_ticks = delay_ticks;
  assign result_o.mode_now    = mode_d;
  assign result_o.turn_busy   = chase_active_d;

endmodule
